// ----- hw/rtl/blac_pkg.sv -----
// Shared types, constants and register codes for the block-level audio compressor.
// No dependencies; the front end, back end, top level and checker import this package.
package blac_pkg;

    localparam int BLOCK_SIZE_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 4;

    localparam int GAIN_W     = 16;
    localparam int RATIO_W    = 16;
    localparam int THR_W      = 15;
    localparam int REL_W      = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int RATIO_FRAC = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_IN_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_OUT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RATIO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REL_LEN  = 3'd5;

    typedef struct packed {
        logic [GAIN_W-1:0]  in_gain;
        logic [GAIN_W-1:0]  out_gain;
        logic [THR_W-1:0]   thr;
        logic [RATIO_W-1:0] ratio;
        logic               mode;      // 0 peak, 1 mean square
        logic [REL_W-1:0]   rel_len;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        in_gain:  16'd4096,
        out_gain: 16'd4096,
        thr:      15'd32767,
        ratio:    16'd32768,
        mode:     1'b0,
        rel_len:  16'd4800
    };

    // per-item tags carried through the queue
    typedef struct packed {
        logic keep;   // sample goes into the block store
        logic last;   // final sample of the block
    } t_item_ctl;

    typedef enum logic [1:0] {
        M_OFF     = 2'd0,
        M_ACTIVE  = 2'd1,
        M_RELEASE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQ,
        B_ACC,
        B_THR,
        B_LIM,
        B_CMP,
        B_RD,
        B_EXC,
        B_CM,
        B_BL1,
        B_BL2,
        B_BL3,
        B_DIV,
        B_OG,
        B_OUT
    } t_bstate;

endpackage

// ----- hw/rtl/blac_fifo.sv -----
// Short item queue between the front and back of the compressor.
// Depends on nothing but its parameters.
module blac_fifo #(
    parameter int W     = 18,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_rd,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : AW'(r_wp + 1'b1);
            end
            if (do_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : AW'(r_rp + 1'b1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ----- hw/rtl/blac_front.sv -----
// Front end: accepts samples, applies the saturating input gain and tags each item
// as stored or dropped before it enters the queue. Uses blac_pkg.
module blac_front
    import blac_pkg::*;
#(
    parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_block_end,
    input  logic [GAIN_W-1:0]             i_in_gain,
    output logic                          o_q_wr,
    input  logic                          i_q_full,
    output logic signed [SAMPLE_BITS-1:0] o_q_x,
    output t_item_ctl                     o_q_ctl
);
    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + GAIN_W;
    localparam int CW = $clog2(BLOCK_SIZE + 1);
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (SB - 1);
    localparam logic [PW-1:0] LIM_POS = LIM_NEG - 1'b1;
    localparam logic [PW-1:0] RND_HALF = PW'(1) << (GAIN_FRAC - 1);

    t_fstate       r_state, n_state;
    logic          r_neg, r_last;
    logic [SB-1:0] r_mag;
    logic [PW-1:0] r_prod;
    logic [CW-1:0] r_cnt;
    logic          accept;
    logic [SB-1:0] s_u;
    logic [PW-1:0] rnd;
    logic [SB-1:0] sat_mag;

    assign s_u     = i_sample_in;
    assign accept  = i_push && !o_full;
    assign rnd     = (r_prod + RND_HALF) >> GAIN_FRAC;
    assign sat_mag = r_neg ? ((rnd > LIM_NEG) ? LIM_NEG[SB-1:0] : rnd[SB-1:0])
                           : ((rnd > LIM_POS) ? LIM_POS[SB-1:0] : rnd[SB-1:0]);
    assign o_q_x        = r_neg ? $signed(~sat_mag + 1'b1) : $signed(sat_mag);
    assign o_q_ctl.keep = (r_cnt < CW'(BLOCK_SIZE));
    assign o_q_ctl.last = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_push) n_state = F_MUL;
            end
            F_MUL:  n_state = F_PUSH;
            F_PUSH: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_full = 1'b1;
        o_q_wr = 1'b0;
        case (r_state)
            F_IDLE:  o_full = 1'b0;
            F_PUSH:  o_q_wr = !i_q_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (o_q_wr) begin
                if (r_last) begin
                    r_cnt <= '0;
                end else if (o_q_ctl.keep) begin
                    r_cnt <= CW'(r_cnt + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg  <= s_u[SB-1];
            r_mag  <= s_u[SB-1] ? SB'(~s_u + 1'b1) : s_u;
            r_last <= i_block_end;
        end
        if (r_state == F_MUL) begin
            r_prod <= r_mag * i_in_gain;
        end
    end

endmodule

// ----- hw/rtl/blac_div.sv -----
// Restoring divider, one quotient bit per cycle, for the release blend.
// Needs the numerator's upper part below the divisor. Depends on nothing else.
module blac_div #(
    parameter int Q_W = 16,
    parameter int D_W = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [Q_W+D_W-1:0] i_num,
    input  logic [D_W-1:0]     i_den,
    output logic               o_done,
    output logic [Q_W-1:0]     o_quot
);
    localparam int NW = $clog2(Q_W + 1);

    logic           r_busy, r_done;
    logic [NW-1:0]  r_cnt;
    logic [D_W-1:0] r_rem, r_den;
    logic [Q_W-1:0] r_q;
    logic [D_W:0]   trial;
    logic           ge;

    assign trial  = {r_rem, r_q[Q_W-1]};
    assign ge     = (trial >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[Q_W+D_W-1:Q_W];
            r_q   <= i_num[Q_W-1:0];
            r_den <= i_den;
            r_cnt <= NW'(Q_W);
        end else if (r_busy) begin
            r_rem <= ge ? D_W'(trial - {1'b0, r_den}) : trial[D_W-1:0];
            r_q   <= {r_q[Q_W-2:0], ge};
            r_cnt <= NW'(r_cnt - 1'b1);
        end
    end

endmodule

// ----- hw/rtl/blac_back.sv -----
// Back end: block store, level detector, threshold test and the per-sample
// compress / release / output-gain sequence. Uses blac_pkg and blac_div.
module blac_back
    import blac_pkg::*;
#(
    parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    input  logic signed [SAMPLE_BITS-1:0] i_q_x,
    input  t_item_ctl                     i_q_ctl,
    input  t_cfg                          i_cfg,
    output logic                          o_res_empty,
    input  logic                          i_res_pop,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_last_out
);
    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = $clog2(BLOCK_SIZE);
    localparam int CW    = $clog2(BLOCK_SIZE + 1);
    localparam int MA_W  = (SB > 2 * THR_W) ? SB : 2 * THR_W;
    localparam int MB_W  = (SB > REL_W) ? SB : REL_W;
    localparam int PW    = MA_W + MB_W;
    localparam int ACC_W = 2 * SB - 2 + CW;
    localparam int VW    = (SB > THR_W) ? SB : THR_W;
    localparam int NUM_W = SB + REL_W;
    localparam int CMPW  = (ACC_W > PW) ? ACC_W : PW;
    localparam logic [PW-1:0] LIM_NEG   = PW'(1) << (SB - 1);
    localparam logic [PW-1:0] LIM_POS   = LIM_NEG - 1'b1;
    localparam logic [PW-1:0] GAIN_HALF = PW'(1) << (GAIN_FRAC - 1);
    localparam logic [PW-1:0] RAT_HALF  = PW'(1) << (RATIO_FRAC - 1);

    t_bstate          r_state, n_state;
    logic [SB-1:0]    mem [BLOCK_SIZE];
    logic [SB-1:0]    r_rdata;
    logic [CW-1:0]    r_fill, r_k;
    logic [ACC_W-1:0] r_acc;
    logic [SB-1:0]    r_mag, r_m, r_cm, r_rm;
    t_item_ctl        r_ctl;
    logic [PW-1:0]    r_prod;
    logic             r_above, r_neg, r_over;
    logic [NUM_W-1:0] r_num;
    t_mode            r_mode;
    logic [REL_W-1:0] r_elapsed;
    logic             r_ovalid, r_olast;
    logic [SB-1:0]    r_osample;

    logic [SB-1:0]    qx_u, q_mag, rd_mag, ex, cm_v, sat_mag, res;
    logic             rd_neg, over_c, need_blend, blk_last, out_free, out_load;
    logic [PW-1:0]    rnd_out;
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;
    logic             mul_en, div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [SB-1:0]    div_quot;

    assign qx_u    = i_q_x;
    assign q_mag   = qx_u[SB-1] ? SB'(~qx_u + 1'b1) : qx_u;
    assign rd_neg  = r_rdata[SB-1];
    assign rd_mag  = rd_neg ? SB'(~r_rdata + 1'b1) : r_rdata;
    assign over_c  = (VW'(rd_mag) > VW'(i_cfg.thr));
    assign ex      = SB'(VW'(rd_mag) - VW'(i_cfg.thr));
    assign cm_v    = r_over ? SB'(VW'(i_cfg.thr) + VW'((r_prod + RAT_HALF) >> RATIO_FRAC))
                            : r_m;
    assign need_blend = (r_mode == M_RELEASE) && (r_elapsed < i_cfg.rel_len) && r_over;
    assign blk_last   = (CW'(r_k + 1'b1) == r_fill);
    assign div_num    = r_num + NUM_W'(r_prod) + NUM_W'(i_cfg.rel_len >> 1);

    assign rnd_out = (r_prod + GAIN_HALF) >> GAIN_FRAC;
    assign sat_mag = r_neg ? ((rnd_out > LIM_NEG) ? LIM_NEG[SB-1:0] : rnd_out[SB-1:0])
                           : ((rnd_out > LIM_POS) ? LIM_POS[SB-1:0] : rnd_out[SB-1:0]);
    assign res      = r_neg ? SB'(~sat_mag + 1'b1) : sat_mag;
    assign out_free = !r_ovalid || i_res_pop;

    assign o_res_empty  = !r_ovalid;
    assign o_sample_out = $signed(r_osample);
    assign o_last_out   = r_olast;

    blac_div #(
        .Q_W(SB),
        .D_W(REL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (i_cfg.rel_len),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) n_state = B_SQ;
            end
            B_SQ:  n_state = B_ACC;
            B_ACC: n_state = r_ctl.last ? B_THR : B_IDLE;
            B_THR: n_state = B_LIM;
            B_LIM: n_state = B_CMP;
            B_CMP: n_state = B_RD;
            B_RD:  n_state = B_EXC;
            B_EXC: n_state = B_CM;
            B_CM:  n_state = need_blend ? B_BL1 : B_OG;
            B_BL1: n_state = B_BL2;
            B_BL2: n_state = B_BL3;
            B_BL3: n_state = B_DIV;
            B_DIV: begin
                if (div_done) n_state = B_OG;
            end
            B_OG:  n_state = B_OUT;
            B_OUT: begin
                if (out_free) n_state = blk_last ? B_IDLE : B_RD;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs: queue pop, shared multiplier operands, divider start, result load
    always_comb begin
        o_q_pop   = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        mul_en    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            B_IDLE: o_q_pop = !i_q_empty;
            B_SQ: begin
                mul_a  = MA_W'(r_mag);
                mul_b  = MB_W'(r_mag);
                mul_en = 1'b1;
            end
            B_THR: begin
                mul_a  = MA_W'(i_cfg.thr);
                mul_b  = MB_W'(i_cfg.thr);
                mul_en = 1'b1;
            end
            B_LIM: begin
                // threshold^2 times sample count
                mul_a  = MA_W'(r_prod[2*THR_W-1:0]);
                mul_b  = MB_W'(r_fill);
                mul_en = 1'b1;
            end
            B_EXC: begin
                mul_a  = MA_W'(ex);
                mul_b  = MB_W'(i_cfg.ratio);
                mul_en = 1'b1;
            end
            B_BL1: begin
                mul_a  = MA_W'(r_cm);
                mul_b  = MB_W'(i_cfg.rel_len - r_elapsed);
                mul_en = 1'b1;
            end
            B_BL2: begin
                mul_a  = MA_W'(r_m);
                mul_b  = MB_W'(r_elapsed);
                mul_en = 1'b1;
            end
            B_BL3: div_start = 1'b1;
            B_OG: begin
                mul_a  = MA_W'(r_rm);
                mul_b  = MB_W'(i_cfg.out_gain);
                mul_en = 1'b1;
            end
            B_OUT: out_load = out_free;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_fill    <= '0;
            r_acc     <= '0;
            r_mode    <= M_OFF;
            r_elapsed <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (o_q_pop && i_q_ctl.keep) begin
                r_fill <= CW'(r_fill + 1'b1);
            end

            if (r_state == B_ACC && r_ctl.keep) begin
                if (i_cfg.mode) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end else if (ACC_W'(r_mag) > r_acc) begin
                    r_acc <= ACC_W'(r_mag);
                end
            end

            if (r_state == B_CM) begin
                case (r_mode)
                    M_ACTIVE: begin
                        if (!r_above) begin
                            r_mode    <= M_RELEASE;
                            r_elapsed <= '0;
                        end
                    end
                    M_RELEASE: begin
                        if (r_elapsed < i_cfg.rel_len) begin
                            r_elapsed <= REL_W'(r_elapsed + 1'b1);
                        end else begin
                            r_mode    <= M_OFF;
                            r_elapsed <= '0;
                        end
                    end
                    default: begin
                        // off, and the unused code
                        if (r_above) begin
                            r_mode    <= M_ACTIVE;
                            r_elapsed <= '0;
                        end
                    end
                endcase
            end

            if (out_load && blk_last) begin
                r_fill <= '0;
                r_acc  <= '0;
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_res_pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_k[AW-1:0]];
        if (o_q_pop) begin
            r_mag <= q_mag;
            r_ctl <= i_q_ctl;
            if (i_q_ctl.keep) begin
                mem[r_fill[AW-1:0]] <= qx_u;
            end
        end
        if (mul_en) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_state == B_CMP) begin
            r_above <= i_cfg.mode ? (CMPW'(r_acc) > CMPW'(r_prod))
                                  : (r_acc > ACC_W'(i_cfg.thr));
            r_k     <= '0;
        end
        if (r_state == B_EXC) begin
            r_m    <= rd_mag;
            r_neg  <= rd_neg;
            r_over <= over_c;
        end
        if (r_state == B_CM) begin
            r_cm <= cm_v;
            if (r_mode == M_ACTIVE) begin
                r_rm <= r_over ? cm_v : r_m;
            end else begin
                r_rm <= r_m;
            end
        end
        if (r_state == B_BL2) begin
            r_num <= NUM_W'(r_prod);
        end
        if (r_state == B_DIV && div_done) begin
            r_rm <= div_quot;
        end
        if (out_load) begin
            r_osample <= res;
            r_olast   <= blk_last;
            r_k       <= CW'(r_k + 1'b1);
        end
    end

endmodule

// ----- hw/rtl/block_level_audio_compressor.sv -----
// Block-level hard-knee compressor, one channel: top level with the register file.
// Uses blac_pkg, blac_front, blac_fifo and blac_back.
//
// Samples enter through push/full; the front end captures each one, multiplies it by the
// input gain and writes it to the queue, and takes no new sample until that write is done.
// A 4-item queue feeds the back end, which stores, squares and accumulates each stored
// sample while a block is being collected. The item flagged block_end starts emission:
// the threshold test, then for each result a store read, excess multiply, mode step,
// output-gain multiply and result register. A result that falls in the release blend
// adds multiply/add steps and a pass through the bit-serial divider. The back end
// shares one multiplier. Input items are still taken during emission until the queue
// fills. The configuration port is always ready; write it only when the block is idle.
module block_level_audio_compressor
    import blac_pkg::*;
#(
    parameter int BLOCK_SIZE  = BLOCK_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic                          i_block_end,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out,
    output logic                          o_last_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);
    localparam int QW = SAMPLE_BITS + 2;

    t_cfg                          r_cfg;
    logic                          q_wr, q_full, q_rd, q_empty;
    logic signed [SAMPLE_BITS-1:0] q_x_in, q_x_out;
    t_item_ctl                     q_ctl_in, q_ctl_out;
    logic [QW-1:0]                 q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_IN_GAIN:  r_cfg.in_gain  <= i_cfg_data;
                CFG_IDX_OUT_GAIN: r_cfg.out_gain <= i_cfg_data;
                CFG_IDX_THR:      r_cfg.thr      <= i_cfg_data[THR_W-1:0];
                CFG_IDX_RATIO:    r_cfg.ratio    <= i_cfg_data;
                CFG_IDX_MODE:     r_cfg.mode     <= i_cfg_data[0];
                CFG_IDX_REL_LEN:  r_cfg.rel_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    blac_front #(
        .BLOCK_SIZE  (BLOCK_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_sample_in (i_sample_in),
        .i_block_end (i_block_end),
        .i_in_gain   (r_cfg.in_gain),
        .o_q_wr      (q_wr),
        .i_q_full    (q_full),
        .o_q_x       (q_x_in),
        .o_q_ctl     (q_ctl_in)
    );

    blac_fifo #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata ({q_ctl_in, q_x_in}),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign q_ctl_out = t_item_ctl'(q_rdata[QW-1:SAMPLE_BITS]);
    assign q_x_out   = $signed(q_rdata[SAMPLE_BITS-1:0]);

    blac_back #(
        .BLOCK_SIZE  (BLOCK_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_rd),
        .i_q_x        (q_x_out),
        .i_q_ctl      (q_ctl_out),
        .i_cfg        (r_cfg),
        .o_res_empty  (empty),
        .i_res_pop    (pop),
        .o_sample_out (o_sample_out),
        .o_last_out   (o_last_out)
    );

endmodule

// ----- hw/rtl/blac_checker.sv -----
// Port-level checks for the compressor top level, attached by the bind below.
// Uses blac_pkg for the default sample width.
module blac_checker
    import blac_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          empty,
    input logic                          pop,
    input logic signed [SAMPLE_BITS-1:0] o_sample_out,
    input logic                          o_last_out
);

    // reset leaves no result waiting and the input side open
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("result pending or input blocked after reset");

    // the front end works on one item at a time
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> full)
        else $error("input accepted on back-to-back cycles");

    // a result not taken stays put
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_sample_out) && $stable(o_last_out))
        else $error("waiting result changed or vanished");

endmodule

bind block_level_audio_compressor blac_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_blac_checker (.*);
